>>> rtl/grid_rectangle_first_fit_allocator_defines.svh
// assertion macros shared by the allocator rtl
`ifndef GRID_RECTANGLE_FIRST_FIT_ALLOCATOR_DEFINES_SVH
`define GRID_RECTANGLE_FIRST_FIT_ALLOCATOR_DEFINES_SVH
`ifndef SYNTH
`define GRFA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("grfa assertion failed");
`define GRFA_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("grfa forbidden condition");
`else
`define GRFA_ASSERT(lbl, clk, rst_n, prop)
`define GRFA_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

>>> rtl/grfa_pkg.sv
// shared types and constants of the grid rectangle allocator
package grfa_pkg;

  localparam int CRD_W   = 6;
  localparam int SUM_W   = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_REGS  = 2;

  localparam logic [2:0] CMD_ADD_FIT = 3'd0;
  localparam logic [2:0] CMD_ADD_AT  = 3'd1;
  localparam logic [2:0] CMD_REMOVE  = 3'd2;
  localparam logic [2:0] CMD_QUERY   = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_PRESENT  = 3'd1;
  localparam logic [2:0] ST_NOFIT    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_BADARG   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_TBL_RD,
    DP_CAND_AT,
    DP_CAND_ZERO,
    DP_CAND_TBL,
    DP_CELL_RD,
    DP_ADVANCE,
    DP_SKIP,
    DP_CUR_RST,
    DP_FILL_SET,
    DP_FILL_CLR,
    DP_TBL_WR,
    DP_TBL_INV,
    DP_CLR_START,
    DP_CLR_STEP
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic       cfg_we;
    logic       result;
    logic [2:0] status;
    logic       show_pos;
    logic       show_cell;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       id_ok;
    logic       size_ok;
    logic       tbl_valid;
    logic       cell_busy;
    logic       rect_last;
    logic       bounds_ok;
    logic       query_in;
    logic       clr_last;
    logic       out_free;
  } dp_sts_t;

endpackage

>>> rtl/grfa_datapath.sv
// datapath of the allocator: grid memory, placement table, cursors, result register
`include "grid_rectangle_first_fit_allocator_defines.svh"
module grfa_datapath import grfa_pkg::*; #(
  parameter int MAX_COLUMNS = 16,
  parameter int MAX_ROWS    = 16,
  parameter int MAX_ITEMS   = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  output dp_sts_t              sts_o,
  input  logic [2:0]           cmd_in_i,
  input  logic [5:0]           item_id_i,
  input  logic [4:0]           size_x_i,
  input  logic [4:0]           size_y_i,
  input  logic [3:0]           pos_x_i,
  input  logic [3:0]           pos_y_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [4:0]           cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           status_o,
  output logic [3:0]           placed_x_o,
  output logic [3:0]           placed_y_o,
  output logic [5:0]           cell_item_o
);

  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int AW = CW + RW;
  localparam int GDEPTH = 1 << AW;
  localparam int TW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  typedef struct packed {
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    logic [4:0]       sx;
    logic [4:0]       sy;
  } tbl_ent_t;

  logic [2:0] cmd_q;
  logic [5:0] id_q;
  logic [4:0] sx_q, sy_q;
  logic [3:0] px_q, py_q;
  logic [4:0] gw_q, gh_q;
  logic [CRD_W-1:0] cand_x_q, cand_y_q, cur_x_q, cur_y_q;
  logic [AW-1:0] clr_addr_q;
  logic [5:0] cell_rd_q;
  logic [MAX_ITEMS-1:0] tbl_valid_q;
  tbl_ent_t tbl_q;
  logic out_valid_q;
  logic [2:0] status_q;
  logic [3:0] placed_x_q, placed_y_q;
  logic [5:0] cell_item_q;

  logic [5:0] grid_mem [GDEPTH];
  tbl_ent_t   tbl_mem [MAX_ITEMS];

  logic [CRD_W-1:0] cols, rows;
  logic [SUM_W-1:0] end_x, end_y, cur_x1, cur_y1, skip_x, skip_end;
  logic [TW-1:0] tidx;
  logic [AW-1:0] cur_addr, gw_addr;
  logic gwe;
  logic [5:0] gw_data;

  // clamp of the configured grid size
  always_comb begin
    if (gw_q == 5'd0) begin
      cols = CRD_W'(1);
    end else if ({2'b00, gw_q} > 7'(MAX_COLUMNS)) begin
      cols = CRD_W'(MAX_COLUMNS);
    end else begin
      cols = CRD_W'(gw_q);
    end
    if (gh_q == 5'd0) begin
      rows = CRD_W'(1);
    end else if ({2'b00, gh_q} > 7'(MAX_ROWS)) begin
      rows = CRD_W'(MAX_ROWS);
    end else begin
      rows = CRD_W'(gh_q);
    end
  end

  assign end_x    = SUM_W'(cand_x_q) + SUM_W'(sx_q);
  assign end_y    = SUM_W'(cand_y_q) + SUM_W'(sy_q);
  assign cur_x1   = SUM_W'(cur_x_q) + SUM_W'(1);
  assign cur_y1   = SUM_W'(cur_y_q) + SUM_W'(1);
  assign skip_x   = cur_x1;
  assign skip_end = skip_x + SUM_W'(sx_q);
  assign tidx     = TW'(id_q);
  assign cur_addr = {cur_y_q[RW-1:0], cur_x_q[CW-1:0]};

  assign sts_o.cmd       = cmd_q;
  assign sts_o.id_ok     = (id_q != 6'd0) && ({3'b000, id_q} < 9'(MAX_ITEMS));
  assign sts_o.size_ok   = (sx_q != 5'd0) && (sy_q != 5'd0);
  assign sts_o.tbl_valid = tbl_valid_q[tidx];
  assign sts_o.cell_busy = (cell_rd_q != 6'd0);
  assign sts_o.rect_last = (cur_x1 == end_x) && (cur_y1 == end_y);
  assign sts_o.bounds_ok = (end_x <= SUM_W'(cols)) && (end_y <= SUM_W'(rows));
  assign sts_o.query_in  = (CRD_W'(px_q) < cols) && (CRD_W'(py_q) < rows);
  assign sts_o.clr_last  = &clr_addr_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // grid write port select
  always_comb begin
    gwe     = 1'b0;
    gw_addr = cur_addr;
    gw_data = 6'd0;
    case (cmd_i.op)
      DP_CLR_STEP: begin
        gwe     = 1'b1;
        gw_addr = clr_addr_q;
      end
      DP_FILL_SET: begin
        gwe     = 1'b1;
        gw_data = id_q;
      end
      DP_FILL_CLR: begin
        gwe = 1'b1;
      end
      default: begin
        gwe = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (gwe) begin
      grid_mem[gw_addr] <= gw_data;
    end
    if (cmd_i.op == DP_CELL_RD) begin
      cell_rd_q <= grid_mem[cur_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_TBL_WR) begin
      tbl_mem[tidx] <= '{x: cand_x_q, y: cand_y_q, sx: sx_q, sy: sy_q};
    end
    if (cmd_i.op == DP_TBL_RD) begin
      tbl_q <= tbl_mem[tidx];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q        <= 5'd16;
      gh_q        <= 5'd16;
      clr_addr_q  <= '0;
      tbl_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cfg_we && cfg_index_i == CFG_WIDTH) begin
        gw_q <= cfg_data_i;
      end
      if (cmd_i.cfg_we && cfg_index_i == CFG_HEIGHT) begin
        gh_q <= cfg_data_i;
      end
      case (cmd_i.op)
        DP_CLR_START: begin
          clr_addr_q  <= '0;
          tbl_valid_q <= '0;
        end
        DP_CLR_STEP: clr_addr_q <= clr_addr_q + AW'(1);
        DP_TBL_WR:   tbl_valid_q[tidx] <= 1'b1;
        DP_TBL_INV:  tbl_valid_q[tidx] <= 1'b0;
        default: begin
        end
      endcase
      if (cmd_i.result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        cmd_q <= cmd_in_i;
        id_q  <= item_id_i;
        sx_q  <= size_x_i;
        sy_q  <= size_y_i;
        px_q  <= pos_x_i;
        py_q  <= pos_y_i;
      end
      DP_CAND_AT: begin
        cand_x_q <= CRD_W'(px_q);
        cand_y_q <= CRD_W'(py_q);
        cur_x_q  <= CRD_W'(px_q);
        cur_y_q  <= CRD_W'(py_q);
      end
      DP_CAND_ZERO: begin
        cand_x_q <= '0;
        cand_y_q <= '0;
        cur_x_q  <= '0;
        cur_y_q  <= '0;
      end
      DP_CAND_TBL: begin
        cand_x_q <= tbl_q.x;
        cand_y_q <= tbl_q.y;
        cur_x_q  <= tbl_q.x;
        cur_y_q  <= tbl_q.y;
        sx_q     <= tbl_q.sx;
        sy_q     <= tbl_q.sy;
      end
      DP_CUR_RST: begin
        cur_x_q <= cand_x_q;
        cur_y_q <= cand_y_q;
      end
      DP_ADVANCE, DP_FILL_SET, DP_FILL_CLR: begin
        if (cur_x1 == end_x) begin
          cur_x_q <= cand_x_q;
          cur_y_q <= CRD_W'(cur_y1);
        end else begin
          cur_x_q <= CRD_W'(cur_x1);
        end
      end
      DP_SKIP: begin
        // every corner up to the busy column overlaps it
        if (skip_end > SUM_W'(cols)) begin
          cand_x_q <= '0;
          cand_y_q <= CRD_W'(SUM_W'(cand_y_q) + SUM_W'(1));
          cur_x_q  <= '0;
          cur_y_q  <= CRD_W'(SUM_W'(cand_y_q) + SUM_W'(1));
        end else begin
          cand_x_q <= CRD_W'(skip_x);
          cur_x_q  <= CRD_W'(skip_x);
          cur_y_q  <= cand_y_q;
        end
      end
      default: begin
      end
    endcase
    if (cmd_i.result) begin
      status_q    <= cmd_i.status;
      placed_x_q  <= cmd_i.show_pos ? cand_x_q[3:0] : 4'd0;
      placed_y_q  <= cmd_i.show_pos ? cand_y_q[3:0] : 4'd0;
      cell_item_q <= cmd_i.show_cell ? cell_rd_q : 6'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign placed_x_o  = placed_x_q;
  assign placed_y_o  = placed_y_q;
  assign cell_item_o = cell_item_q;

  `GRFA_ASSERT(a_result_slot_free, clk_i, rst_ni, cmd_i.result |-> (!out_valid_q || out_ready_i))
  `GRFA_ASSERT(a_tbl_wr_sets, clk_i, rst_ni, (cmd_i.op == DP_TBL_WR) |=> sts_o.tbl_valid)
  `GRFA_ASSERT(a_tbl_inv_clears, clk_i, rst_ni, (cmd_i.op == DP_TBL_INV) |=> !sts_o.tbl_valid)
  `GRFA_ASSERT_NEVER(a_fill_in_bounds, clk_i, rst_ni, (cmd_i.op == DP_FILL_SET) && !sts_o.bounds_ok)

endmodule

>>> rtl/grfa_ctrl.sv
// controller state machine of the allocator
module grfa_ctrl import grfa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  output logic                 cfg_ready_o,
  output dp_cmd_t              cmd_o,
  input  dp_sts_t              sts_i
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DECODE, S_TABLE, S_CHECK, S_TEST,
    S_RD, S_FILL, S_FIN, S_QRD, S_RESULT
  } state_e;

  state_e state_q, state_d;
  logic [2:0] res_status_q, res_status_d;
  logic res_pos_q, res_pos_d, res_cell_q, res_cell_d;
  logic pending_q, pending_d;
  logic is_add;

  assign is_add      = (sts_i.cmd == CMD_ADD_FIT) || (sts_i.cmd == CMD_ADD_AT);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;

  always_comb begin
    state_d      = state_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_cell_d   = res_cell_q;
    pending_d    = pending_q;
    cmd_o        = '{op: DP_NOP, cfg_we: 1'b0, result: 1'b0, status: res_status_q,
                     show_pos: res_pos_q, show_cell: res_cell_q};
    case (state_q)
      S_CLR: begin
        cmd_o.op = DP_CLR_STEP;
        if (sts_i.clr_last) begin
          state_d = pending_q ? S_RESULT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (cfg_valid_i) begin
          cmd_o.cfg_we = 1'b1;
          if (cfg_index_i < CFG_IDX_W'(CFG_REGS)) begin
            cmd_o.op  = DP_CLR_START;
            pending_d = 1'b0;
            state_d   = S_CLR;
          end
        end else if (in_valid_i) begin
          cmd_o.op   = DP_LOAD;
          res_pos_d  = 1'b0;
          res_cell_d = 1'b0;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.op = DP_TBL_RD;
        state_d  = S_TABLE;
      end
      S_TABLE: begin
        state_d = S_RESULT;
        case (sts_i.cmd)
          CMD_ADD_FIT, CMD_ADD_AT: begin
            if (!sts_i.id_ok || !sts_i.size_ok) begin
              res_status_d = ST_BADARG;
            end else if (sts_i.tbl_valid) begin
              cmd_o.op     = DP_CAND_TBL;
              res_status_d = ST_PRESENT;
              res_pos_d    = 1'b1;
            end else begin
              cmd_o.op = (sts_i.cmd == CMD_ADD_AT) ? DP_CAND_AT : DP_CAND_ZERO;
              state_d  = S_CHECK;
            end
          end
          CMD_REMOVE: begin
            if (!sts_i.id_ok) begin
              res_status_d = ST_BADARG;
            end else if (!sts_i.tbl_valid) begin
              res_status_d = ST_NOTFOUND;
            end else begin
              cmd_o.op = DP_CAND_TBL;
              state_d  = S_FILL;
            end
          end
          CMD_QUERY: begin
            cmd_o.op = DP_CAND_AT;
            state_d  = S_QRD;
          end
          CMD_CLEAR: begin
            cmd_o.op     = DP_CLR_START;
            res_status_d = ST_DONE;
            pending_d    = 1'b1;
            state_d      = S_CLR;
          end
          default: begin
            res_status_d = ST_BADARG;
          end
        endcase
      end
      S_CHECK: begin
        if (!sts_i.bounds_ok) begin
          res_status_d = ST_NOFIT;
          state_d      = S_RESULT;
        end else begin
          cmd_o.op = DP_CELL_RD;
          state_d  = S_TEST;
        end
      end
      S_RD: begin
        cmd_o.op = DP_CELL_RD;
        state_d  = S_TEST;
      end
      S_TEST: begin
        if (sts_i.cell_busy) begin
          if (sts_i.cmd == CMD_ADD_AT) begin
            res_status_d = ST_NOFIT;
            state_d      = S_RESULT;
          end else begin
            cmd_o.op = DP_SKIP;
            state_d  = S_CHECK;
          end
        end else if (sts_i.rect_last) begin
          cmd_o.op = DP_CUR_RST;
          state_d  = S_FILL;
        end else begin
          cmd_o.op = DP_ADVANCE;
          state_d  = S_RD;
        end
      end
      S_FILL: begin
        cmd_o.op = is_add ? DP_FILL_SET : DP_FILL_CLR;
        if (sts_i.rect_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.op     = is_add ? DP_TBL_WR : DP_TBL_INV;
        res_status_d = ST_DONE;
        res_pos_d    = 1'b1;
        state_d      = S_RESULT;
      end
      S_QRD: begin
        cmd_o.op     = DP_CELL_RD;
        res_status_d = ST_DONE;
        res_cell_d   = sts_i.query_in;
        state_d      = S_RESULT;
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.result = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      res_status_q <= ST_DONE;
      res_pos_q    <= 1'b0;
      res_cell_q   <= 1'b0;
      pending_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      res_status_q <= res_status_d;
      res_pos_q    <= res_pos_d;
      res_cell_q   <= res_cell_d;
      pending_q    <= pending_d;
    end
  end

endmodule

>>> rtl/grid_rectangle_first_fit_allocator.sv
// top level of the grid rectangle first-fit allocator
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i/in_ready_o   | cmd, item_id, size_x, size_y, pos_x, pos_y
//  out     | output    | out_valid_o/out_ready_i | status, placed_x, placed_y, cell_item
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index (0 width, 1 height), cfg_data
//
// one item at a time; a query passes decode, table, cell read and result; bad arguments
//   and present ids go from table to result; add reads and tests each scanned cell,
//   then fills the cells of the item; a busy cell moves an add-fit corner past it
// remove clears each cell of the item, then invalidates its table entry
// reset, clear-all and a width or height write sweep all grid memory entries,
//   2**(clog2(MAX_ROWS)+clog2(MAX_COLUMNS)) of them (256 by default), no item taken then
// a pending item waits in the output register while the next item is accepted
module grid_rectangle_first_fit_allocator import grfa_pkg::*; #(
  parameter int MAX_COLUMNS = 16,
  parameter int MAX_ROWS    = 16,
  parameter int MAX_ITEMS   = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           cmd_i,
  input  logic [5:0]           item_id_i,
  input  logic [4:0]           size_x_i,
  input  logic [4:0]           size_y_i,
  input  logic [3:0]           pos_x_i,
  input  logic [3:0]           pos_y_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           status_o,
  output logic [3:0]           placed_x_o,
  output logic [3:0]           placed_y_o,
  output logic [5:0]           cell_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [4:0]           cfg_data_i
);

  // command and status between the state machine and the datapath
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  grfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (dp_cmd),
    .sts_i       (dp_sts)
  );

  // grid memory, placement table and the result register
  grfa_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .MAX_ITEMS   (MAX_ITEMS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .cmd_in_i    (cmd_i),
    .item_id_i   (item_id_i),
    .size_x_i    (size_x_i),
    .size_y_i    (size_y_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .placed_x_o  (placed_x_o),
    .placed_y_o  (placed_y_o),
    .cell_item_o (cell_item_o)
  );

endmodule
